### src/lce_pkg.sv
// Shared types and constants for the LRU cache with batch eviction.
package lce_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BATCH_DEF = 8;
    localparam int MAX_LINES_DEF = 8;
    localparam int ID_WIDTH_DEF  = 16;

    // Fixed field widths
    localparam int ACC_ID_W   = 16;
    localparam int MISS_W     = 32;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] BATCH_RST = 4'd4;
    localparam logic [CFG_W-1:0] LINES_RST = 4'd8;

    // Result kinds
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_EVICT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_EVICT_RD,
        ST_EVICT_OUT,
        ST_SHIFT,
        ST_WRITE,
        ST_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;       // latch new id, rewind pointer
        logic rd;          // read tag store at pointer, advance pointer
        logic hit;         // match found: set up shift by one
        logic miss;        // bump miss counter, set up eviction
        logic shift_wr;    // write read data down by shift amount
        logic wr_tail;     // write id as most recent, update count
        logic out_evict;   // load eviction word into output register
        logic out_access;  // load access word into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rvalid;       // read data present this cycle
        logic match;        // read data equals current id
        logic ptr_lt_cnt;   // pointer below resident count
        logic ptr_eq_shift; // pointer reached eviction count
        logic full;         // resident count at or above capacity
        logic out_free;     // output register can take a word
    } t_status;

endpackage

### src/lce_in_if.sv
// Input channel: one entry id per word.
interface lce_in_if;
    logic                          valid;
    logic                          ready;
    logic [lce_pkg::ACC_ID_W-1:0]  access_id;

    modport source (output valid, output access_id, input ready);
    modport sink   (input valid, input access_id, output ready);
endinterface

### src/lce_out_if.sv
// Output channel: access results and eviction notices.
interface lce_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [lce_pkg::ACC_ID_W-1:0]  result_id;
    logic                          hit;
    logic [lce_pkg::MISS_W-1:0]     miss_count;
    logic                          last;

    modport source (output valid, output kind, output result_id, output hit,
                    output miss_count, output last, input ready);
    modport sink   (input valid, input kind, input result_id, input hit,
                    input miss_count, input last, output ready);
endinterface

### src/lce_ctrl.sv
// Controller state machine sequencing lookup, eviction, compaction and insert.
module lce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lce_pkg::t_status i_st,
    output lce_pkg::t_cmd    o_cmd
);

    lce_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lce_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = lce_pkg::ST_SCAN;
                end
            end
            lce_pkg::ST_SCAN: begin
                priority if (i_st.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = lce_pkg::ST_SHIFT;
                end else if (i_st.ptr_lt_cnt) begin
                    o_cmd.rd = 1'b1;
                end else if (!i_st.rvalid) begin
                    n_state = lce_pkg::ST_MISS;
                end
            end
            lce_pkg::ST_MISS: begin
                o_cmd.miss = 1'b1;
                n_state    = i_st.full ? lce_pkg::ST_EVICT_RD : lce_pkg::ST_WRITE;
            end
            lce_pkg::ST_EVICT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = lce_pkg::ST_EVICT_OUT;
            end
            lce_pkg::ST_EVICT_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_evict = 1'b1;
                    n_state = i_st.ptr_eq_shift ? lce_pkg::ST_SHIFT : lce_pkg::ST_EVICT_RD;
                end
            end
            lce_pkg::ST_SHIFT: begin
                o_cmd.shift_wr = i_st.rvalid;
                o_cmd.rd       = i_st.ptr_lt_cnt;
                if (!i_st.ptr_lt_cnt && !i_st.rvalid) begin
                    n_state = lce_pkg::ST_WRITE;
                end
            end
            lce_pkg::ST_WRITE: begin
                o_cmd.wr_tail = 1'b1;
                n_state       = lce_pkg::ST_RESULT;
            end
            lce_pkg::ST_RESULT: begin
                if (i_st.out_free) begin
                    o_cmd.out_access = 1'b1;
                    n_state          = lce_pkg::ST_IDLE;
                end
            end
            default: n_state = lce_pkg::ST_IDLE;
        endcase
    end

endmodule

### src/lce_dpath.sv
// Datapath: recency-ordered tag memory, counters, config and output register.
module lce_dpath #(
    parameter int MAX_BATCH = lce_pkg::MAX_BATCH_DEF,
    parameter int MAX_LINES = lce_pkg::MAX_LINES_DEF,
    parameter int ID_WIDTH  = lce_pkg::ID_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lce_pkg::ACC_ID_W-1:0]    i_access_id,
    input  logic                            i_cfg_we,
    input  logic [lce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lce_pkg::CFG_W-1:0]       i_cfg_data,
    input  lce_pkg::t_cmd                   i_cmd,
    output lce_pkg::t_status                o_st,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_out_kind,
    output logic [lce_pkg::ACC_ID_W-1:0]    o_out_id,
    output logic                            o_out_hit,
    output logic [lce_pkg::MISS_W-1:0]      o_out_miss,
    output logic                            o_out_last
);

    localparam int SLOTS = MAX_BATCH * MAX_LINES;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int BW    = $clog2(MAX_BATCH + 1);
    localparam int LW    = $clog2(MAX_LINES + 1);
    localparam int TAG_W = (ID_WIDTH < lce_pkg::ACC_ID_W) ? ID_WIDTH : lce_pkg::ACC_ID_W;

    // Tag memory, slot 0 holds the oldest resident
    logic [TAG_W-1:0] r_tag_mem [SLOTS];

    logic [lce_pkg::CFG_W-1:0]  r_batch, r_lines;
    logic [TAG_W-1:0]           r_tag;
    logic [TAG_W-1:0]           r_rdata;
    logic                       r_rvalid;
    logic [CNT_W-1:0]           r_ridx;
    logic [CNT_W-1:0]           r_ptr;
    logic [CNT_W-1:0]           r_shift;
    logic [CNT_W-1:0]           r_count;
    logic [lce_pkg::MISS_W-1:0] r_misses;
    logic                       r_hit;

    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [lce_pkg::ACC_ID_W-1:0] r_out_id;
    logic                       r_out_hit;
    logic [lce_pkg::MISS_W-1:0] r_out_miss;
    logic                       r_out_last;

    logic [BW-1:0]    batch_eff;
    logic [LW-1:0]    lines_eff;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] evict_cnt;
    logic             out_free;
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    logic [TAG_W-1:0] wr_data;

    // Registers saturate into their legal range; zero acts as one
    always_comb begin
        if (r_batch == '0) begin
            batch_eff = BW'(1);
        end else if (32'(r_batch) > MAX_BATCH) begin
            batch_eff = BW'(MAX_BATCH);
        end else begin
            batch_eff = BW'(r_batch);
        end
        if (r_lines == '0) begin
            lines_eff = LW'(1);
        end else if (32'(r_lines) > MAX_LINES) begin
            lines_eff = LW'(MAX_LINES);
        end else begin
            lines_eff = LW'(r_lines);
        end
    end

    assign cap       = CNT_W'(batch_eff) * CNT_W'(lines_eff);
    assign evict_cnt = (CNT_W'(batch_eff) < r_count) ? CNT_W'(batch_eff) : r_count;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_st.rvalid       = r_rvalid;
    assign o_st.match        = r_rvalid && (r_rdata == r_tag);
    assign o_st.ptr_lt_cnt   = r_ptr < r_count;
    assign o_st.ptr_eq_shift = r_ptr == r_shift;
    assign o_st.full         = r_count >= cap;
    assign o_st.out_free     = out_free;

    // Single write port: compaction moves or tail insert
    always_comb begin
        wr_en   = i_cmd.shift_wr || i_cmd.wr_tail;
        wr_data = i_cmd.shift_wr ? r_rdata : r_tag;
        priority if (i_cmd.shift_wr) begin
            wr_addr = r_ridx - r_shift;
        end else if (r_hit) begin
            wr_addr = r_count - CNT_W'(1);
        end else begin
            wr_addr = r_count - r_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tag_mem[wr_addr[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_tag_mem[r_ptr[IDX_W-1:0]];
            r_ridx  <= r_ptr;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch     <= lce_pkg::BATCH_RST;
            r_lines     <= lce_pkg::LINES_RST;
            r_count     <= '0;
            r_misses    <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lce_pkg::CFG_BATCH_SIZE:   r_batch <= i_cfg_data;
                    lce_pkg::CFG_LINES_IN_USE: r_lines <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rvalid <= i_cmd.rd;
            if (i_cmd.miss) begin
                r_misses <= r_misses + lce_pkg::MISS_W'(1);
            end
            if (i_cmd.wr_tail && !r_hit) begin
                r_count <= r_count - r_shift + CNT_W'(1);
            end
            if (i_cmd.out_evict || i_cmd.out_access) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.start) begin
            r_tag <= i_access_id[TAG_W-1:0];
            r_ptr <= '0;
        end else if (i_cmd.hit) begin
            r_ptr   <= r_ridx + CNT_W'(1);
            r_shift <= CNT_W'(1);
            r_hit   <= 1'b1;
        end else if (i_cmd.miss) begin
            r_ptr   <= '0;
            r_shift <= o_st.full ? evict_cnt : '0;
            r_hit   <= 1'b0;
        end else if (i_cmd.rd) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_evict) begin
            r_out_kind <= lce_pkg::KIND_EVICT;
            r_out_id   <= lce_pkg::ACC_ID_W'(r_rdata);
            r_out_hit  <= 1'b0;
            r_out_miss <= '0;
            r_out_last <= 1'b0;
        end else if (i_cmd.out_access) begin
            r_out_kind <= lce_pkg::KIND_ACCESS;
            r_out_id   <= lce_pkg::ACC_ID_W'(r_tag);
            r_out_hit  <= r_hit;
            r_out_miss <= r_misses;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_id    = r_out_id;
    assign o_out_hit   = r_out_hit;
    assign o_out_miss  = r_out_miss;
    assign o_out_last  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("resident count above slot count");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_evict || i_cmd.out_access) |-> out_free)
        else $error("output word overwritten while stalled");

    a_shift_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |-> (r_ridx >= r_shift && r_ridx < r_count))
        else $error("compaction write out of range");

    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.miss |=> (r_misses == $past(r_misses) + lce_pkg::MISS_W'(1)))
        else $error("miss counter did not advance");

endmodule

### src/lru_cache_batch_evict.sv
// Top level: fully associative LRU tag store with batch eviction.
// Usage
//   i_in_ch  : one entry id per word (valid/ready). Low ID_WIDTH bits are the tag.
//   o_out_ch : result words. Each access ends with one word of kind 0 (hit flag,
//              running miss count, last=1). A miss on a full store (resident count
//              at or above batch_size*lines_in_use) is preceded by one kind 1 word
//              per evicted id, oldest first, with last=0.
//   cfg port : i_cfg_we/i_cfg_idx/i_cfg_data write batch_size (0) or lines_in_use
//              (1); write only while idle. Out-of-range values saturate.
// Sequence
//   The tag memory is scanned oldest to newest through its single read port, then
//   entries above the hit (or the evicted batch) move down one per cycle.
// Reset
//   Synchronous, active low: store empty, miss count zero, batch_size 4,
//   lines_in_use 8. No memory clearing pass; only entries below the count are read.
// Stall
//   Results sit in an output register; a stalled receiver holds the sequencer at
//   its next result word, and the input stays not ready until the access is done.
module lru_cache_batch_evict #(
    parameter int MAX_BATCH = lce_pkg::MAX_BATCH_DEF,
    parameter int MAX_LINES = lce_pkg::MAX_LINES_DEF,
    parameter int ID_WIDTH  = lce_pkg::ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lce_in_if.sink                        i_in_ch,
    lce_out_if.source                     o_out_ch,
    input  logic                          i_cfg_we,
    input  logic [lce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lce_pkg::CFG_W-1:0]     i_cfg_data
);

    lce_pkg::t_cmd    cmd;
    lce_pkg::t_status st;

    // Sequencer
    lce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (i_in_ch.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Tag memory, counters and output word
    lce_dpath #(
        .MAX_BATCH (MAX_BATCH),
        .MAX_LINES (MAX_LINES),
        .ID_WIDTH  (ID_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_access_id (i_in_ch.access_id),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_out_kind  (o_out_ch.kind),
        .o_out_id    (o_out_ch.result_id),
        .o_out_hit   (o_out_ch.hit),
        .o_out_miss  (o_out_ch.miss_count),
        .o_out_last  (o_out_ch.last)
    );

endmodule

### sim/lce_checker.sv
// Scoreboard for the LRU cache: tracks residency and recency, checks every result word.
`timescale 1ns / 100ps
module lce_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lce_in_if                             in_ch,
    lce_out_if                            out_ch,
    input  logic                          i_cfg_we,
    input  logic [lce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lce_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int SLOTS  = lce_pkg::MAX_BATCH_DEF * lce_pkg::MAX_LINES_DEF;
    localparam int SLOT_W = $clog2(SLOTS);

    typedef struct {
        logic                           kind;
        logic [lce_pkg::ACC_ID_W-1:0]   result_id;
        logic                           hit;
        logic [lce_pkg::MISS_W-1:0]     miss_count;
        logic                           last;
    } t_result_word;

    t_result_word                 result_q[$];
    logic [lce_pkg::ACC_ID_W-1:0] tags [SLOTS];
    logic                         slot_used [SLOTS];
    logic [SLOT_W-1:0]            lru_order [SLOTS];   // slot numbers, oldest first
    int                           resident_n;
    logic [lce_pkg::MISS_W-1:0]   miss_total;
    logic [lce_pkg::CFG_W-1:0]    batch_reg;
    logic [lce_pkg::CFG_W-1:0]    lines_reg;
    int                           n_fail = 0;

    task automatic lookup_and_update(input logic [lce_pkg::ACC_ID_W-1:0] id);
        int                batch;
        int                lines;
        int                cap;
        int                pos;
        int                hit_pos;
        int                evict_n;
        int                free_slot;
        logic [SLOT_W-1:0] s;
        batch   = (batch_reg == '0) ? 1 :
                  ((int'(batch_reg) > lce_pkg::MAX_BATCH_DEF) ? lce_pkg::MAX_BATCH_DEF
                                                              : int'(batch_reg));
        lines   = (lines_reg == '0) ? 1 :
                  ((int'(lines_reg) > lce_pkg::MAX_LINES_DEF) ? lce_pkg::MAX_LINES_DEF
                                                              : int'(lines_reg));
        cap     = batch * lines;
        hit_pos = -1;
        for (pos = 0; pos < resident_n; pos++) begin
            if (hit_pos < 0 && slot_used[lru_order[pos]] && tags[lru_order[pos]] == id) begin
                hit_pos = pos;
            end
        end
        if (hit_pos >= 0) begin
            // hit: rotate the entry to most recent
            s = lru_order[hit_pos];
            for (pos = hit_pos; pos + 1 < resident_n; pos++) begin
                lru_order[pos] = lru_order[pos + 1];
            end
            lru_order[resident_n - 1] = s;
            result_q.insert(result_q.size(),
                            '{lce_pkg::KIND_ACCESS, id, 1'b1, miss_total, 1'b1});
        end else begin
            miss_total = miss_total + lce_pkg::MISS_W'(1);
            if (resident_n >= cap) begin
                // full: drop one batch from the old end, even if still above capacity
                evict_n = (batch < resident_n) ? batch : resident_n;
                for (pos = 0; pos < evict_n; pos++) begin
                    s            = lru_order[pos];
                    slot_used[s] = 1'b0;
                    result_q.insert(result_q.size(),
                                    '{lce_pkg::KIND_EVICT, tags[s], 1'b0, '0, 1'b0});
                end
                for (pos = 0; pos + evict_n < resident_n; pos++) begin
                    lru_order[pos] = lru_order[pos + evict_n];
                end
                resident_n -= evict_n;
            end
            free_slot = -1;
            for (pos = 0; pos < SLOTS; pos++) begin
                if (free_slot < 0 && !slot_used[pos]) begin
                    free_slot = pos;
                end
            end
            if (free_slot >= 0 && resident_n < SLOTS) begin
                tags[free_slot]       = id;
                slot_used[free_slot]  = 1'b1;
                lru_order[resident_n] = SLOT_W'(free_slot);
                resident_n++;
            end
            result_q.insert(result_q.size(),
                            '{lce_pkg::KIND_ACCESS, id, 1'b0, miss_total, 1'b1});
        end
    endtask

    task automatic check_field(input string name, input logic [lce_pkg::MISS_W-1:0] exp_v,
                               input logic [lce_pkg::MISS_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result_word exp_w;
        if (!i_rst_n) begin
            foreach (slot_used[k]) begin
                slot_used[k] = 1'b0;
                tags[k]      = '0;
                lru_order[k] = '0;
            end
            resident_n = 0;
            miss_total = '0;
            batch_reg  = lce_pkg::BATCH_RST;
            lines_reg  = lce_pkg::LINES_RST;
            result_q.delete();
        end else begin
            // outputs first: a word accepted now can only belong to an earlier access
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result word: kind %0d id %0h", out_ch.kind,
                           out_ch.result_id);
                    n_fail++;
                end else begin
                    exp_w = result_q[0];
                    result_q.delete(0);
                    check_field("kind", lce_pkg::MISS_W'(exp_w.kind),
                                lce_pkg::MISS_W'(out_ch.kind));
                    check_field("result_id", lce_pkg::MISS_W'(exp_w.result_id),
                                lce_pkg::MISS_W'(out_ch.result_id));
                    check_field("hit", lce_pkg::MISS_W'(exp_w.hit),
                                lce_pkg::MISS_W'(out_ch.hit));
                    check_field("miss_count", exp_w.miss_count, out_ch.miss_count);
                    check_field("last", lce_pkg::MISS_W'(exp_w.last),
                                lce_pkg::MISS_W'(out_ch.last));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lce_pkg::CFG_BATCH_SIZE:   batch_reg = i_cfg_data;
                    lce_pkg::CFG_LINES_IN_USE: lines_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                lookup_and_update(in_ch.access_id);
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= n_fail;
    end

endmodule

### sim/tb_top.sv
// Testbench top: drives access ids and register writes into the LRU cache, reports the verdict.
`timescale 1ns / 100ps
module tb_top;

    // Far above the slowest legal run: ~370 accesses, each at most a full
    // 64-entry scan plus 8 evictions, with the receiver stalling half the time.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_N      = 96;
    localparam int RECENT_N    = 16;
    localparam int SETTLE      = 16;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [lce_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [lce_pkg::CFG_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;
    int                            cycles = 0;
    int                            snd_idle_pct;
    int                            rcv_idle_pct;
    int                            cap_now;     // effective capacity, shapes the id mix
    logic [lce_pkg::ACC_ID_W-1:0]  recent_ids[$];
    logic [lce_pkg::ACC_ID_W-1:0]  id_pool[POOL_N];

    lce_in_if  in_ch ();
    lce_out_if out_ch ();

    lru_cache_batch_evict u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lce_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one id and hold it until accepted. Valid is left high on
    // return so back-to-back words never drop it within one time step.
    task automatic send_id(input logic [lce_pkg::ACC_ID_W-1:0] id);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.access_id <= id;
        do @(posedge i_clk); while (!in_ch.ready);
        recent_ids.insert(recent_ids.size(), id);
        if (recent_ids.size() > RECENT_N) begin
            recent_ids.delete(0);
        end
    endtask

    // Stop sending and wait until every predicted word has come back.
    // The first edge lets the checker see the last accepted word.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Both registers, back to back; only called with the block idle
    task automatic set_config(input logic [lce_pkg::CFG_W-1:0] batch,
                              input logic [lce_pkg::CFG_W-1:0] lines);
        int b_eff;
        int l_eff;
        cfg_we   <= 1'b1;
        cfg_idx  <= lce_pkg::CFG_BATCH_SIZE;
        cfg_data <= batch;
        @(posedge i_clk);
        cfg_idx  <= lce_pkg::CFG_LINES_IN_USE;
        cfg_data <= lines;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        b_eff    = (batch == '0) ? 1 :
                   ((int'(batch) > lce_pkg::MAX_BATCH_DEF) ? lce_pkg::MAX_BATCH_DEF
                                                           : int'(batch));
        l_eff    = (lines == '0) ? 1 :
                   ((int'(lines) > lce_pkg::MAX_LINES_DEF) ? lce_pkg::MAX_LINES_DEF
                                                           : int'(lines));
        cap_now  = b_eff * l_eff;
    endtask

    // Random accesses: a mix of recently used ids (mostly hits), a pool a bit
    // larger than capacity (fills, then batch evictions) and a little noise.
    task automatic run_block(input int n_words);
        int                           pool_n;
        int                           r;
        logic [lce_pkg::ACC_ID_W-1:0] id;
        pool_n = cap_now + cap_now / 4 + 2;
        foreach (id_pool[k]) id_pool[k] = lce_pkg::ACC_ID_W'($urandom);
        for (int i = 0; i < n_words; i++) begin
            r = $urandom_range(99);
            if (r < 40 && recent_ids.size() > 0) begin
                id = recent_ids[$urandom_range(recent_ids.size() - 1)];
            end else if (r < 90) begin
                id = id_pool[$urandom_range(pool_n - 1)];
            end else if (r < 93) begin
                id = '0;
            end else if (r < 96) begin
                id = '1;
            end else begin
                id = lce_pkg::ACC_ID_W'($urandom);
            end
            send_id(id);
            // mid-block pause: let the pipe run completely dry
            if (i == n_words / 2) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.access_id <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= lce_pkg::CFG_BATCH_SIZE;
        cfg_data        <= '0;
        i_rst_n         <= 1'b0;
        snd_idle_pct    = 7;
        rcv_idle_pct    <= 55;
        cap_now         = 32;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest store, one entry; hit, miss-with-eviction, id extremes
        set_config(4'd1, 4'd1);
        send_id(16'h0000);
        send_id(16'h0000);
        send_id(16'hFFFF);
        send_id(16'hFFFF);
        send_id(16'h0000);

        // One full line of 8: fill it, then hit on a middle entry
        wait_drained();
        set_config(4'd8, 4'd1);
        for (int k = 0; k < 7; k++) begin
            send_id(lce_pkg::ACC_ID_W'(1) << k);
        end
        send_id(16'h0002);

        // Capacity dropped under the resident count (zeros act as one):
        // each miss evicts one entry only, store stays over capacity
        wait_drained();
        set_config(4'd0, 4'd0);
        send_id(16'h5555);
        send_id(16'hAAAA);

        // Back to a line of 8 while 8 are resident: a whole batch goes at once
        wait_drained();
        set_config(4'd8, 4'd1);
        send_id(16'h7FFF);

        // Phase 1: receiver stalls heavily
        wait_drained();
        set_config(4'd2, 4'd3);
        run_block(46);
        wait_drained();
        set_config(4'd15, 4'd15);     // saturates to the full 64-entry store
        run_block(104);

        // Phase 2: sender idles heavily
        wait_drained();
        snd_idle_pct = 55;
        rcv_idle_pct <= 7;
        set_config(4'd1, 4'd8);
        run_block(48);
        wait_drained();
        set_config(4'd5, 4'd2);
        run_block(50);

        // Phase 3: full throughput on both sides
        wait_drained();
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        set_config(4'd9, 4'd1);
        run_block(48);
        wait_drained();
        set_config(4'd4, 4'd4);
        run_block(56);

        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
